FILE: src/vertex_transform_project_core_macros.svh
// Assertion macros used by the checker file of the vertex transform core.
`ifndef VERTEX_TRANSFORM_PROJECT_CORE_MACROS_SVH
`define VERTEX_TRANSFORM_PROJECT_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define VTP_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define VTP_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: src/vtp_pkg.sv
// Shared constants, types and helper functions of the vertex transform core.
package vtp_pkg;

    localparam int FieldW       = 16;
    localparam int CoefFracBits = 12;
    localparam int FracQ        = 12;
    localparam int OneQ12       = 4096;
    localparam int ProdW        = 32;
    localparam int AccW         = 34;
    localparam int MagW         = 33;
    localparam int NumW         = 46;
    localparam int DenW         = 34;
    localparam int RemW         = 34;
    localparam int DivStages    = NumW;
    localparam int NdcW         = 32;
    localparam int NdcLimit     = 2 ** 30;
    localparam int VpW          = 12;
    localparam int VpProdW      = 46;
    localparam int RndW         = 34;
    localparam int RndShift     = 13;
    localparam int SatW         = 48;
    localparam int RowW         = 64;
    localparam int CfgIdxW      = 3;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] RegRow0   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegRow1   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegRow2   = 3'd2;
    localparam logic [CfgIdxW-1:0] RegRow3   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegWidth  = 3'd4;
    localparam logic [CfgIdxW-1:0] RegHeight = 3'd5;
    localparam logic [CfgIdxW-1:0] RegOrigin = 3'd6;

    localparam logic [VpW-1:0] WidthReset  = 12'd299;
    localparam logic [VpW-1:0] HeightReset = 12'd189;
    localparam logic [VpW-1:0] OriginReset = 12'd190;

    // Side information that travels with a vertex through the divider.
    typedef struct packed {
        logic [2:0] neg;
        logic       divided;
    } vtp_meta_t;

    // Saturate a wide signed value to 16-bit signed.
    function automatic logic signed [FieldW-1:0] sat16(input logic signed [SatW-1:0] v);
        logic signed [FieldW-1:0] r;
        if (v > SatW'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -SatW'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[FieldW-1:0];
        end
        return r;
    endfunction

    // Divide by 2^13 and round to nearest, ties away from zero.
    function automatic logic signed [RndW-1:0] round_q13(input logic signed [VpProdW-1:0] n);
        logic [VpProdW-1:0] mag;
        logic [VpProdW-1:0] q;
        mag = (n < 0) ? VpProdW'(-n) : VpProdW'(n);
        q   = (mag + VpProdW'(1 << (RndShift - 1))) >> RndShift;
        return (n < 0) ? -$signed(RndW'(q)) : $signed(RndW'(q));
    endfunction

endpackage

FILE: src/vtp_matmul.sv
// Matrix-vector product and divider operand preparation, three pipeline stages.
module vtp_matmul
    import vtp_pkg::*;
(
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [FieldW-1:0]        vertex_x,
    input  logic signed [FieldW-1:0]        vertex_y,
    input  logic signed [FieldW-1:0]        vertex_z,
    input  logic signed [FieldW-1:0]        vertex_w,
    input  logic [3:0][RowW-1:0]            matrix,
    output logic                            out_valid,
    output logic [2:0][NumW-1:0]            out_num,
    output logic [DenW-1:0]                 out_den,
    output vtp_meta_t                       out_meta
);

    logic signed [FieldW-1:0] vin [4];
    logic signed [ProdW-1:0]  prod_reg [4][4];
    logic signed [AccW-1:0]   acc_reg [4];
    logic                     v1_reg, v2_reg, v3_reg;
    logic [2:0][NumW-1:0]     num_next, num_reg;
    logic [DenW-1:0]          den_next, den_reg;
    vtp_meta_t                meta_next, meta_reg;

    assign vin[0] = vertex_x;
    assign vin[1] = vertex_y;
    assign vin[2] = vertex_z;
    assign vin[3] = vertex_w;

    // Valid bits of the three stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1: sixteen coefficient products.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    prod_reg[r][c] <= ProdW'($signed(matrix[r][FieldW*c +: FieldW]))
                                    * ProdW'(vin[c]);
                end
            end
        end
    end

    // Stage 2: row sums.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                acc_reg[r] <= AccW'(prod_reg[r][0]) + AccW'(prod_reg[r][1])
                            + AccW'(prod_reg[r][2]) + AccW'(prod_reg[r][3]);
            end
        end
    end

    // Stage 3: rounding numerator 2m+d, with m = |a| scaled by 2^12 when dividing, and denominator 2d for each lane.
    always_comb begin
        logic [MagW-1:0] mag;
        logic [MagW-1:0] d;
        logic [NumW-1:0] m;
        meta_next.divided = (acc_reg[3] > 0);
        d = meta_next.divided ? MagW'(acc_reg[3]) : MagW'(1 << CoefFracBits);
        den_next = DenW'(d) << 1;
        for (int l = 0; l < 3; l++) begin
            meta_next.neg[l] = acc_reg[l][AccW-1];
            mag = acc_reg[l][AccW-1] ? MagW'(-acc_reg[l]) : MagW'(acc_reg[l]);
            m   = meta_next.divided ? (NumW'(mag) << FracQ) : NumW'(mag);
            num_next[l] = (m << 1) + NumW'(d);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            meta_reg <= meta_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_meta  = meta_reg;

endmodule

FILE: src/vtp_divider.sv
// Restoring divider for three lanes, one quotient bit per pipeline stage.
module vtp_divider
    import vtp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [2:0][NumW-1:0]    in_num,
    input  logic [DenW-1:0]         in_den,
    input  vtp_meta_t               in_meta,
    output logic                    out_valid,
    output logic [2:0][NumW-1:0]    out_quo,
    output vtp_meta_t               out_meta
);

    // Stage inputs: index 0 comes from the ports, index s from stage s-1.
    logic [RemW-1:0]  rem_w  [DivStages][3];
    logic [NumW-1:0]  num_w  [DivStages][3];
    logic [NumW-1:0]  quo_w  [DivStages][3];
    logic [DenW-1:0]  den_w  [DivStages];
    vtp_meta_t        meta_w [DivStages];
    logic             vld_w  [DivStages];

    logic [RemW-1:0]  rem_reg  [DivStages-1][3];
    logic [NumW-1:0]  num_reg  [DivStages-1][3];
    logic [DenW-1:0]  den_reg  [DivStages-1];
    logic [NumW-1:0]  quo_reg  [DivStages][3];
    vtp_meta_t        meta_reg [DivStages];
    logic             vld_reg  [DivStages];

    assign den_w[0]  = in_den;
    assign meta_w[0] = in_meta;
    assign vld_w[0]  = in_valid;

    for (genvar l = 0; l < 3; l++) begin : g_in
        assign rem_w[0][l] = '0;
        assign num_w[0][l] = in_num[l];
        assign quo_w[0][l] = '0;
    end

    for (genvar s = 0; s < DivStages; s++) begin : g_stage
        // Valid bit of this stage.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_w[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                meta_reg[s] <= meta_w[s];
            end
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [RemW:0] trial;
            logic          ge;

            // Shift in the next numerator bit and try to subtract.
            assign trial = {rem_w[s][l], num_w[s][l][NumW-1]};
            assign ge    = (trial >= {1'b0, den_w[s]});

            always_ff @(posedge aclk) begin
                if (en) begin
                    quo_reg[s][l] <= {quo_w[s][l][NumW-2:0], ge};
                end
            end

            if (s < DivStages - 1) begin : g_carry
                always_ff @(posedge aclk) begin
                    if (en) begin
                        rem_reg[s][l] <= ge ? RemW'(trial - {1'b0, den_w[s]})
                                            : trial[RemW-1:0];
                        num_reg[s][l] <= {num_w[s][l][NumW-2:0], 1'b0};
                    end
                end
                assign rem_w[s+1][l] = rem_reg[s][l];
                assign num_w[s+1][l] = num_reg[s][l];
                assign quo_w[s+1][l] = quo_reg[s][l];
            end
        end

        if (s < DivStages - 1) begin : g_next
            always_ff @(posedge aclk) begin
                if (en) begin
                    den_reg[s] <= den_w[s];
                end
            end
            assign den_w[s+1]  = den_reg[s];
            assign meta_w[s+1] = meta_reg[s];
            assign vld_w[s+1]  = vld_reg[s];
        end
    end

    assign out_valid = vld_reg[DivStages-1];
    assign out_meta  = meta_reg[DivStages-1];
    for (genvar l = 0; l < 3; l++) begin : g_out
        assign out_quo[l] = quo_reg[DivStages-1][l];
    end

endmodule

FILE: src/vtp_viewport.sv
// Sign restore, viewport mapping, rounding and saturation, four pipeline stages.
module vtp_viewport
    import vtp_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [2:0][NumW-1:0]        in_quo,
    input  vtp_meta_t                   in_meta,
    input  logic [VpW-1:0]              width_m1,
    input  logic [VpW-1:0]              height_m1,
    input  logic [VpW-1:0]              y_origin,
    output logic                        m_valid,
    output logic signed [FieldW-1:0]    m_screen_x,
    output logic signed [FieldW-1:0]    m_screen_y,
    output logic signed [FieldW-1:0]    m_depth,
    output logic                        m_divided
);

    logic                        v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [NdcW-1:0]      ndc_next [3];
    logic signed [NdcW-1:0]      ndc_reg  [3];
    logic                        div1_reg, div2_reg, div3_reg, div4_reg;
    logic signed [VpProdW-1:0]   px_reg, py_reg;
    logic signed [FieldW-1:0]    dep2_reg, dep3_reg, dep4_reg;
    logic signed [RndW-1:0]      rx_reg, ry_reg;
    logic signed [FieldW-1:0]    sx_reg, sy_reg;

    // Valid bits of the four stages; the last one is the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage 1: clamp the quotient magnitude and restore the sign. Any value
    // beyond the clamp saturates every later result anyway.
    always_comb begin
        logic [NdcW-1:0] mag;
        for (int l = 0; l < 3; l++) begin
            mag = (in_quo[l] > NumW'(NdcLimit)) ? NdcW'(NdcLimit) : in_quo[l][NdcW-1:0];
            ndc_next[l] = in_meta.neg[l] ? -$signed(mag) : $signed(mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                ndc_reg[l] <= ndc_next[l];
            end
            div1_reg <= in_meta.divided;
        end
    end

    // Stage 2: scale by the viewport size; depth saturates here.
    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg   <= VpProdW'((NdcW+1)'(ndc_reg[0]) + (NdcW+1)'(OneQ12))
                      * VpProdW'($signed({1'b0, width_m1}));
            py_reg   <= VpProdW'((NdcW+1)'(OneQ12) - (NdcW+1)'(ndc_reg[1]))
                      * VpProdW'($signed({1'b0, height_m1}));
            dep2_reg <= sat16(SatW'(ndc_reg[2]));
            div2_reg <= div1_reg;
        end
    end

    // Stage 3: halve the NDC span and round to whole pixels.
    always_ff @(posedge aclk) begin
        if (en) begin
            rx_reg   <= round_q13(px_reg);
            ry_reg   <= round_q13(py_reg);
            dep3_reg <= dep2_reg;
            div3_reg <= div2_reg;
        end
    end

    // Stage 4: add the row origin and saturate into the output register.
    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg   <= sat16(SatW'(rx_reg));
            sy_reg   <= sat16(SatW'(ry_reg) + SatW'($signed({1'b0, y_origin})));
            dep4_reg <= dep3_reg;
            div4_reg <= div3_reg;
        end
    end

    assign m_valid    = v4_reg;
    assign m_screen_x = sx_reg;
    assign m_screen_y = sy_reg;
    assign m_depth    = dep4_reg;
    assign m_divided  = div4_reg;

endmodule

FILE: src/vertex_transform_project_core.sv
// Top level of the vertex transform, perspective divide and viewport core.
//
// Vertices enter on the s_ channel (valid/ready), one request per cycle
// while s_ready is high, as four signed Q4.12 fields. Each is multiplied
// by the 4x4 matrix held in the configuration registers, divided by w when
// w is positive, and mapped to pixel coordinates that leave on the m_
// channel with a depth and a flag. An accepted input passes through three
// stages of matrix product, one stage per quotient bit in the 46-stage
// divider, and four stages of viewport mapping to the output register.
// Throughput is one vertex per cycle. The whole pipeline advances together:
// when the receiver holds m_ready low while a result is shown, every stage
// freezes and s_ready drops, so nothing is lost or repeated.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata) and
// must only be written while the pipeline is empty.
// Synchronous reset clears all valid bits and loads the register defaults:
// a zero matrix, width 299, height 189 and row origin 190.
module vertex_transform_project_core
    import vtp_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [FieldW-1:0]    s_vertex_x,
    input  logic signed [FieldW-1:0]    s_vertex_y,
    input  logic signed [FieldW-1:0]    s_vertex_z,
    input  logic signed [FieldW-1:0]    s_vertex_w,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [FieldW-1:0]    m_screen_x,
    output logic signed [FieldW-1:0]    m_screen_y,
    output logic signed [FieldW-1:0]    m_depth,
    output logic                        m_divided,
    input  logic                        cfg_wr_en,
    input  logic [CfgIdxW-1:0]          cfg_index,
    input  logic [RowW-1:0]             cfg_wdata
);

    logic [3:0][RowW-1:0]  row_reg;
    logic [VpW-1:0]        width_reg, height_reg, origin_reg;
    logic                  en;
    logic                  mm_valid, dv_valid;
    logic [2:0][NumW-1:0]  mm_num, dv_quo;
    logic [DenW-1:0]       mm_den;
    vtp_meta_t             mm_meta, dv_meta;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg    <= '0;
            width_reg  <= WidthReset;
            height_reg <= HeightReset;
            origin_reg <= OriginReset;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                RegRow0, RegRow1, RegRow2, RegRow3: begin
                    row_reg[cfg_index[1:0]] <= cfg_wdata;
                end
                RegWidth:  width_reg  <= cfg_wdata[VpW-1:0];
                RegHeight: height_reg <= cfg_wdata[VpW-1:0];
                RegOrigin: origin_reg <= cfg_wdata[VpW-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output register is empty or being taken.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    vtp_matmul u_matmul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .vertex_x  (s_vertex_x),
        .vertex_y  (s_vertex_y),
        .vertex_z  (s_vertex_z),
        .vertex_w  (s_vertex_w),
        .matrix    (row_reg),
        .out_valid (mm_valid),
        .out_num   (mm_num),
        .out_den   (mm_den),
        .out_meta  (mm_meta)
    );

    vtp_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mm_valid),
        .in_num    (mm_num),
        .in_den    (mm_den),
        .in_meta   (mm_meta),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_meta  (dv_meta)
    );

    vtp_viewport u_viewport (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (dv_valid),
        .in_quo     (dv_quo),
        .in_meta    (dv_meta),
        .width_m1   (width_reg),
        .height_m1  (height_reg),
        .y_origin   (origin_reg),
        .m_valid    (m_valid),
        .m_screen_x (m_screen_x),
        .m_screen_y (m_screen_y),
        .m_depth    (m_depth),
        .m_divided  (m_divided)
    );

endmodule

FILE: src/vtp_checker.sv
// Port-level assertion checker for the vertex transform core, with its bind.
`include "vertex_transform_project_core_macros.svh"

module vtp_checker
    import vtp_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic signed [FieldW-1:0]    m_screen_x,
    input  logic signed [FieldW-1:0]    m_screen_y,
    input  logic signed [FieldW-1:0]    m_depth,
    input  logic                        m_divided
);

    // A stalled result stays offered with its payload unchanged.
    `VTP_ASSERT_CLK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_screen_x) && $stable(m_screen_y) && $stable(m_depth) && $stable(m_divided), "result changed while stalled")

    // The input side is ready exactly when the output register can move.
    `VTP_ASSERT_CLK(a_ready_link, s_ready == (!m_valid || m_ready), "input ready out of step with output")

    // A cleared pipeline shows no result after reset.
    `VTP_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result valid right after reset")

    // The input side is ready in the cycle after reset.
    `VTP_ASSERT_RST(a_reset_ready, !aresetn |=> s_ready, "input not ready after reset")

endmodule

bind vertex_transform_project_core vtp_checker u_vtp_checker (.*);
